[sv/mrd64_pkg.sv]
// Package: shared types, constants and witness tables for the primality tester.
package mrd64_pkg;

   localparam int unsigned WordWidth = 64;
   localparam int unsigned RowCount  = 9;
   localparam int unsigned MaxBases  = 12;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_BASE,
      ST_POW_MUL,
      ST_POW_SQR,
      ST_CHECK,
      ST_SQUARE,
      ST_SQ_CHECK,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } mul_ctl_type;

   function automatic word_type row_bound(input logic [3:0] r);
      word_type v;
      case (r)
         4'd0: v = 64'd2046;
         4'd1: v = 64'd9080190;
         4'd2: v = 64'd4759123140;
         4'd3: v = 64'd1122004669632;
         4'd4: v = 64'd2152302898746;
         4'd5: v = 64'd3474749660382;
         4'd6: v = 64'd341550071728320;
         4'd7: v = 64'd3825123056546413050;
         default: v = '1;
      endcase
      return v;
   endfunction

   function automatic logic [3:0] row_len(input logic [3:0] r);
      logic [3:0] v;
      case (r)
         4'd0: v = 4'd1;
         4'd1: v = 4'd2;
         4'd2: v = 4'd3;
         4'd3: v = 4'd4;
         4'd4: v = 4'd5;
         4'd5: v = 4'd6;
         4'd6: v = 4'd7;
         4'd7: v = 4'd9;
         default: v = 4'd12;
      endcase
      return v;
   endfunction

   function automatic logic [20:0] row_base(input logic [3:0] r, input logic [3:0] k);
      logic [20:0] v;
      logic [20:0] small_primes [12];
      small_primes = '{21'd2, 21'd3, 21'd5, 21'd7, 21'd11, 21'd13, 21'd17, 21'd19,
                       21'd23, 21'd29, 21'd31, 21'd37};
      case (r)
         4'd0: v = 21'd2;
         4'd1: v = (k == 4'd0) ? 21'd31 : 21'd73;
         4'd2: v = (k == 4'd0) ? 21'd2 : (k == 4'd1) ? 21'd7 : 21'd61;
         4'd3: v = (k == 4'd0) ? 21'd2 : (k == 4'd1) ? 21'd13 :
                   (k == 4'd2) ? 21'd23 : 21'd1662803;
         default: v = (k < 4'd12) ? small_primes[k] : 21'd2;
      endcase
      return v;
   endfunction

endpackage

[sv/mrd64_mulmod.sv]
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
module mrd64_mulmod #(
   parameter int unsigned Width = mrd64_pkg::WordWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [Width-1:0] a,
   input  logic [Width-1:0] b,
   input  logic [Width-1:0] m,
   output logic             busy,
   output logic [Width-1:0] product
);

   localparam int unsigned CountWidth = $clog2(Width + 1);

   logic [Width-1:0]      r_ff, r_in;
   logic [Width-1:0]      b_ff, b_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;

   // (x + y) mod m for x, y < m
   function automatic logic [Width-1:0] add_mod(input logic [Width-1:0] x,
                                                input logic [Width-1:0] y,
                                                input logic [Width-1:0] mm);
      logic [Width-1:0] gap;
      gap = mm - y;
      return (x >= gap) ? (x - gap) : (x + y);
   endfunction

   always_comb begin
      logic [Width-1:0] dbl;
      r_in    = r_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      dbl     = add_mod(r_ff, r_ff, m);
      if (start) begin
         r_in    = '0;
         b_in    = b;
         cnt_in  = CountWidth'(Width);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // double, then add the multiplicand for a set bit
         r_in   = b_ff[Width-1] ? add_mod(dbl, a, m) : dbl;
         b_in   = {b_ff[Width-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CountWidth'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign busy    = busy_ff;
   assign product = r_ff;

   a_busy_counts: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("busy with zero count");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("start did not raise busy");
   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) && m != '0 && $stable(m) |-> r_ff < m)
      else $error("product not reduced");

endmodule

[sv/mrd64_ctrl.sv]
// Sequencer: row selection, witness loop, exponentiation and squaring steps.
module mrd64_ctrl #(
   parameter int unsigned Width = mrd64_pkg::WordWidth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [Width-1:0]      req_candidate,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_prime,
   output mrd64_pkg::mul_ctl_type mul_ctl,
   input  logic                  mul_busy,
   input  logic [Width-1:0]      mul_product,
   output logic [Width-1:0]      mul_a,
   output logic [Width-1:0]      mul_b
);

   localparam int unsigned SWidth = $clog2(Width);

   mrd64_pkg::state_type state_ff, state_in;
   logic [Width-1:0]  x_ff, x_in;
   logic [Width-1:0]  d_ff, d_in;
   logic [SWidth-1:0] s_ff, s_in;
   logic [SWidth-1:0] i_ff, i_in;
   logic [Width-1:0]  e_ff, e_in;
   logic [Width-1:0]  y_ff, y_in;
   logic [Width-1:0]  p_ff, p_in;
   logic [3:0]        row_ff, row_in;
   logic [3:0]        k_ff, k_in;
   logic              res_ff, res_in;
   logic              out_v_ff, out_v_in;
   logic              issued_ff, issued_in;

   logic [Width-1:0] xm1;
   logic             mul_done;
   assign xm1      = x_ff - 1'b1;
   assign mul_done = issued_ff && !mul_busy;

   always_comb begin
      logic [Width-1:0] base;
      state_in  = state_ff;
      x_in = x_ff; d_in = d_ff; s_in = s_ff; i_in = i_ff; e_in = e_ff;
      y_in = y_ff; p_in = p_ff; row_in = row_ff; k_in = k_ff;
      res_in = res_ff; out_v_in = out_v_ff; issued_in = issued_ff;
      mul_ctl   = '0;
      mul_a     = y_ff;
      mul_b     = p_ff;
      base      = Width'(mrd64_pkg::row_base(row_ff, k_ff));
      if (out_v_ff && !rsp_stall) out_v_in = 1'b0;
      case (state_ff)
         mrd64_pkg::ST_IDLE: begin
            if (req_valid && !out_v_ff) begin
               x_in   = req_candidate;
               d_in   = req_candidate - 1'b1;
               s_in   = '0;
               row_in = '0;
               k_in   = '0;
               if (req_candidate < Width'(2)) begin
                  res_in = 1'b0; state_in = mrd64_pkg::ST_DONE;
               end else if (req_candidate == Width'(2)) begin
                  res_in = 1'b1; state_in = mrd64_pkg::ST_DONE;
               end else if (!req_candidate[0]) begin
                  res_in = 1'b0; state_in = mrd64_pkg::ST_DONE;
               end else begin
                  state_in = mrd64_pkg::ST_SETUP;
               end
            end
         end
         mrd64_pkg::ST_SETUP: begin
            // strip twos from x-1 and find the row, one step a cycle
            if (!d_ff[0] && s_ff != SWidth'(Width - 1)) begin
               d_in = d_ff >> 1;
               s_in = s_ff + 1'b1;
            end else if (row_ff != 4'(mrd64_pkg::RowCount - 1) &&
                         !(x_ff < mrd64_pkg::row_bound(row_ff))) begin
               row_in = row_ff + 1'b1;
            end else begin
               state_in = mrd64_pkg::ST_BASE;
            end
         end
         mrd64_pkg::ST_BASE: begin
            if (x_ff == base) begin
               res_in = 1'b1; state_in = mrd64_pkg::ST_DONE;
            end else begin
               y_in = Width'(1);
               p_in = (base < x_ff) ? base : base - x_ff;
               e_in = d_ff;
               i_in = SWidth'(1);
               state_in = mrd64_pkg::ST_POW_MUL;
            end
         end
         mrd64_pkg::ST_POW_MUL: begin
            if (e_ff == '0) begin
               state_in = mrd64_pkg::ST_CHECK;
            end else if (!e_ff[0]) begin
               state_in = mrd64_pkg::ST_POW_SQR;
            end else if (!issued_ff) begin
               mul_ctl.start = 1'b1; issued_in = 1'b1;
            end else if (mul_done) begin
               y_in = mul_product; issued_in = 1'b0;
               state_in = mrd64_pkg::ST_POW_SQR;
            end
         end
         mrd64_pkg::ST_POW_SQR: begin
            mul_a = p_ff;
            if (!issued_ff) begin
               mul_ctl.start = 1'b1; issued_in = 1'b1;
            end else if (mul_done) begin
               p_in = mul_product; issued_in = 1'b0;
               e_in = e_ff >> 1;
               state_in = mrd64_pkg::ST_POW_MUL;
            end
         end
         mrd64_pkg::ST_CHECK: begin
            if (y_ff == Width'(1) || y_ff == xm1) state_in = mrd64_pkg::ST_NEXT;
            else state_in = mrd64_pkg::ST_SQ_CHECK;
         end
         mrd64_pkg::ST_SQ_CHECK: begin
            if (i_ff >= s_ff) begin
               res_in = 1'b0; state_in = mrd64_pkg::ST_DONE;
            end else begin
               state_in = mrd64_pkg::ST_SQUARE;
            end
         end
         mrd64_pkg::ST_SQUARE: begin
            mul_b = y_ff;
            if (!issued_ff) begin
               mul_ctl.start = 1'b1; issued_in = 1'b1;
            end else if (mul_done) begin
               y_in = mul_product; issued_in = 1'b0;
               i_in = i_ff + 1'b1;
               state_in = (mul_product == xm1) ? mrd64_pkg::ST_NEXT
                                               : mrd64_pkg::ST_SQ_CHECK;
            end
         end
         mrd64_pkg::ST_NEXT: begin
            if (k_ff + 1'b1 >= mrd64_pkg::row_len(row_ff)) begin
               res_in = 1'b1; state_in = mrd64_pkg::ST_DONE;
            end else begin
               k_in = k_ff + 1'b1; state_in = mrd64_pkg::ST_BASE;
            end
         end
         mrd64_pkg::ST_DONE: begin
            if (!out_v_ff || !rsp_stall) begin
               out_v_in = 1'b1; state_in = mrd64_pkg::ST_IDLE;
            end
         end
         default: state_in = mrd64_pkg::ST_IDLE;
      endcase
      mul_ctl.busy = issued_ff;
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; d_ff <= d_in; s_ff <= s_in; i_ff <= i_in; e_ff <= e_in;
      y_ff <= y_in; p_ff <= p_in; row_ff <= row_in; k_ff <= k_in;
      res_ff <= res_in;
      if (reset) begin
         state_ff  <= mrd64_pkg::ST_IDLE;
         out_v_ff  <= 1'b0;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         out_v_ff  <= out_v_in;
         issued_ff <= issued_in;
      end
   end

   // res_ff holds the verdict from the deciding state until the next verdict is decided
   assign req_stall    = (state_ff != mrd64_pkg::ST_IDLE) || out_v_ff;
   assign rsp_valid    = out_v_ff;
   assign rsp_is_prime = res_ff;

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != mrd64_pkg::ST_IDLE |-> req_stall) else $error("accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_prime))
      else $error("response dropped under stall");
   a_issue_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == mrd64_pkg::ST_IDLE |-> !issued_ff) else $error("multiply left open");

endmodule

[sv/miller_rabin_deterministic_64.sv]
// Top level: deterministic 64-bit Miller-Rabin primality tester.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_candidate[63:0]
//   rsp      out        rsp_valid/rsp_stall   rsp_is_prime
//
// One candidate at a time. Trivial cases (below two, two, even) go from the accept
// straight to the done state, which raises rsp_valid. Otherwise every modular product
// goes through the bit-serial multiplier: up to twelve witnesses, each with up to
// 2*63 products for the power and up to 62 squarings.
// Reset is synchronous and clears the sequencer, rsp_valid and the multiplier busy flag.
// The result register holds under rsp_stall; req_stall stays high from accept
// until the result beat has been taken.
module miller_rabin_deterministic_64 #(
   parameter int unsigned Width = mrd64_pkg::WordWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [Width-1:0] req_candidate,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_is_prime
);

   mrd64_pkg::mul_ctl_type mul_ctl;
   logic             mul_busy;
   logic [Width-1:0] mul_product, mul_a, mul_b;

   // sequencer: owns the witness loop and the handshakes
   mrd64_ctrl #(.Width(Width)) u_ctrl (
      .clock, .reset,
      .req_valid, .req_stall, .req_candidate,
      .rsp_valid, .rsp_stall, .rsp_is_prime,
      .mul_ctl, .mul_busy, .mul_product, .mul_a, .mul_b
   );

   // shared bit-serial multiplier, modulus is the held candidate
   logic [Width-1:0] modulus_ff;
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) modulus_ff <= req_candidate;
   end

   mrd64_mulmod #(.Width(Width)) u_mul (
      .clock, .reset,
      .start(mul_ctl.start),
      .a(mul_a), .b(mul_b), .m(modulus_ff),
      .busy(mul_busy), .product(mul_product)
   );

endmodule

[bench/primality_checker.sv]
// Checker: watches both channels, predicts primality verdicts and compares them.
module primality_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_candidate,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_is_prime,
   output int          fail_count,
   output int          verdicts_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [63:0] u64_type;

   bit        verdict_q [$];
   u64_type   cand_q [$];

   function automatic u64_type mod_product(u64_type a, u64_type b, u64_type m);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return u64_type'(p % 128'(m));
   endfunction

   function automatic u64_type mod_power(u64_type a, u64_type e, u64_type m);
      u64_type r;
      r = 1;
      a = a % m;
      while (e != 0) begin
         if (e[0]) r = mod_product(r, a, m);
         a = mod_product(a, a, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic bit strong_round(u64_type x, u64_type a);
      u64_type d;
      u64_type y;
      int s;
      d = x - 1;
      s = 0;
      while (d[0] == 1'b0 && s < 63) begin
         d = d >> 1;
         s++;
      end
      y = mod_power(a, d, x);
      if (y == 1 || y == x - 1) return 1'b1;
      // squaring stops one short of a^(x-1)
      for (int i = 1; i < s; i++) begin
         y = mod_product(y, y, x);
         if (y == x - 1) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit primality_verdict(u64_type x);
      u64_type bounds [8];
      u64_type bases [$];
      int row;
      bounds = '{64'd2046, 64'd9080190, 64'd4759123140, 64'd1122004669632,
                 64'd2152302898746, 64'd3474749660382, 64'd341550071728320,
                 64'd3825123056546413050};
      if (x < 2) return 1'b0;
      if (x == 2) return 1'b1;
      if (x[0] == 1'b0) return 1'b0;
      row = 8;
      for (int r = 7; r >= 0; r--) if (x < bounds[r]) row = r;
      case (row)
         0: bases = '{64'd2};
         1: bases = '{64'd31, 64'd73};
         2: bases = '{64'd2, 64'd7, 64'd61};
         3: bases = '{64'd2, 64'd13, 64'd23, 64'd1662803};
         4: bases = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11};
         5: bases = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13};
         6: bases = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17};
         7: bases = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19,
                      64'd23};
         default: bases = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17,
                            64'd19, 64'd23, 64'd29, 64'd31, 64'd37};
      endcase
      foreach (bases[k]) begin
         if (x == bases[k]) return 1'b1;
         if (!strong_round(x, bases[k])) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   initial begin
      fail_count    = 0;
      verdicts_owed = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            verdict_q.push_back(primality_verdict(req_candidate));
            cand_q.push_back(req_candidate);
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               report("verdict beat with no candidate outstanding");
            end else begin
               if (rsp_is_prime !== verdict_q[0])
                  report($sformatf("candidate %0d: is_prime %b, want %b",
                                   cand_q[0], rsp_is_prime, verdict_q[0]));
               void'(verdict_q.pop_front());
               void'(cand_q.pop_front());
            end
         end
         verdicts_owed = verdict_q.size();
      end
   end
endmodule

[bench/miller_rabin_deterministic_64_tb.sv]
// Testbench top: drives candidates and verdict stalls, gives the final verdict.
module miller_rabin_deterministic_64_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_candidate = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_prime;
   int          fail_count;
   int          verdicts_owed;

   // receiver controls: long hold request and a quiet (never stall) window
   int          hold_cycles = 0;
   bit          rsp_quiet = 1'b0;
   bit          stimulus_done = 1'b0;

   always #2 clock = ~clock;

   miller_rabin_deterministic_64 i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_candidate (req_candidate),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_prime  (rsp_is_prime)
   );

   primality_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_candidate (req_candidate),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_prime  (rsp_is_prime),
      .fail_count    (fail_count),
      .verdicts_owed (verdicts_owed)
   );

   // Gap length: mostly short, now and then long.
   function automatic int gap_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
      return $urandom_range(10, 60);
   endfunction

   // Offer one candidate beat and hold it until accepted; return at a falling edge.
   task automatic send_candidate(logic [63:0] value);
      req_valid     <= 1'b1;
      req_candidate <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid for a random gap (zero means back-to-back).
   task automatic sender_gap(bit allow_idle);
      int n;
      n = allow_idle ? gap_len() : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Random candidate: mostly small odd numbers so most runs stay short,
   // a few wider ones, up to full width, so every input bit toggles.
   function automatic logic [63:0] random_candidate();
      logic [63:0] v;
      int          bits;
      v    = {$urandom, $urandom};
      bits = ($urandom_range(0, 99) < 85) ? $urandom_range(2, 24) : $urandom_range(25, 64);
      if (bits < 64) v = v & ((64'd1 << bits) - 1);
      if ($urandom_range(0, 9) < 8) v[0] = 1'b1;
      return v;
   endfunction

   // Receiver: random stall bursts, forced long hold, or quiet windows.
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall   <= 1'b1;
            hold_cycles = hold_cycles - 1;
         end else if (rsp_quiet || stimulus_done) begin
            rsp_stall <= 1'b0;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst     = burst - 1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            burst     = gap_len();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [63:0] directed [$];
      directed = '{
         64'd0, 64'd1, 64'd2, 64'd3, 64'd4,
         64'd341,                       // Fermat liar for base 2, caught by the squaring
         64'd2045, 64'd2047,            // either side of the first row bound
         64'd31, 64'd73, 64'd7, 64'd61, // candidates equal to a witness of some row
         64'd13, 64'd23, 64'd1662803,
         64'd9080191,                   // strong liar for 31 and 73, next row takes it
         64'd4759123141,                // strong liar for 2, 7, 61
         64'd1000000007,
         64'd3825123056546413051,       // strong liar for first nine bases, last row
         64'hFFFF_FFFF_FFFF_FFFF,       // largest value, tested with the last row
         64'hFFFF_FFFF_FFFF_FFC5,       // largest 64-bit prime
         64'h8000_0000_0000_0000,
         64'h5555_5555_5555_5555,
         64'hAAAA_AAAA_AAAA_AAAB
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed candidates back to back, receiver always ready
      rsp_quiet = 1'b1;
      foreach (directed[i]) send_candidate(directed[i]);
      req_valid <= 1'b0;
      rsp_quiet = 1'b0;

      // pause until every verdict is in
      while (verdicts_owed != 0) @(negedge clock);

      // long receiver hold while the sender keeps offering
      hold_cycles = 2000;
      for (int i = 0; i < 4; i++) send_candidate(random_candidate());

      for (int i = 0; i < 100; i++) begin
         if (i == 50) begin
            req_valid <= 1'b0;
            while (verdicts_owed != 0) @(negedge clock);
         end
         // quiet stretch with no idling on either side
         rsp_quiet = (i >= 70 && i < 80);
         send_candidate(random_candidate());
         sender_gap(!rsp_quiet);
      end
      req_valid     <= 1'b0;
      stimulus_done = 1'b1;

      while (verdicts_owed != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("miller_rabin_deterministic_64_tb OK");
      end else begin
         $display("miller_rabin_deterministic_64_tb NOT OK");
      end
      $finish;
   end

   // hang guard
   initial begin
      #500_000_000;
      $display("miller_rabin_deterministic_64_tb NOT OK");
      $finish;
   end
endmodule
